// File: rtl/core/dsr_pkg.sv
package dsr_pkg;

  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagInteger  = 8'h02;
  localparam logic [7:0] PaddedLen   = 8'h21;
  localparam logic [7:0] KeptPadLen  = 8'h20;
  localparam logic [7:0] MaxRawReset = 8'd64;

  // APB register map: one 32-bit register, word addressed
  localparam int unsigned AddrWidth  = 3;
  localparam logic        RegMaxRaw  = 1'b0;   // paddr[2] of max_raw_bytes

  typedef struct packed {
    logic [7:0] der_byte;
    logic       first;
  } der_in_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       has_byte;
    logic       is_last;
    logic       fault;
    logic [7:0] raw_count;
  } raw_out_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SEQ_LEN,
    PH_R_TAG,
    PH_R_LEN,
    PH_R_PAD,
    PH_R_DATA,
    PH_S_TAG,
    PH_S_LEN,
    PH_S_PAD,
    PH_S_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RK_BYTE,
    RK_LAST,
    RK_TOTAL,
    RK_FAULT
  } res_kind_t;

  // Classified result, passed from the parser to the output side
  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] data;
    logic [7:0] count;
  } res_item_t;

endpackage

// File: rtl/core/der_ecdsa_signature_to_raw_core.sv
// Channel   Signals                                       Direction
// --------  --------------------------------------------  ---------
// input     in_valid / in_ready / in_data (der_in_t)      in
// output    out_valid / out_ready / out_data (raw_out_t)  out
// config    psel penable pwrite paddr pwdata prdata pready APB
//
// One DER byte is accepted every cycle while the queue has room; the parser
// state update is a single compare-and-subtract step, which sets the rate at
// one transaction per clock. A result passes through the two-entry queue and
// then through the output register.
// Reset (synchronous, rst high) returns the parser to idle, empties the queue
// and sets max_raw_bytes to 64.
// in_ready drops only when the queue is full, which takes a stalled output.
module der_ecdsa_signature_to_raw_core import dsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  der_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output raw_out_t             out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [7:0] max_raw_bytes;
  logic       cfg_write;

  logic       push;
  res_item_t  push_item;
  logic       q_ready;
  logic       q_valid;
  res_item_t  q_item;
  logic       pop;

  // Configuration register: write on the APB access phase, never stall
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegMaxRaw);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_bytes <= MaxRawReset;
    end else if (cfg_write) begin
      max_raw_bytes <= pwdata[7:0];
    end
  end

  // Read back the buffer size; unmapped words read zero
  assign prdata = (paddr[2] == RegMaxRaw) ? {24'd0, max_raw_bytes} : 32'd0;

  // Front: accept bytes, walk the DER structure, classify each transaction
  dsr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .max_raw_bytes (max_raw_bytes),
    .q_ready       (q_ready),
    .push          (push),
    .push_item     (push_item)
  );

  // Decouple the parser from output backpressure
  dsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Back: build the result fields and hold them in the output register
  dsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/dsr_front.sv
module dsr_front import dsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  der_in_t    in_data,
  input  logic [7:0] max_raw_bytes,
  input  logic       q_ready,
  output logic       push,
  output res_item_t  push_item
);

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] r_kept, r_kept_next;
  logic [7:0] s_kept, s_kept_next;

  logic       in_fire;
  logic [7:0] b;
  logic [7:0] dec;
  logic [7:0] s_limit;

  assign in_ready = q_ready;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.der_byte;
  assign dec      = bytes_left - 8'd1;
  assign s_limit  = max_raw_bytes - r_kept;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= '0;
      r_kept     <= '0;
      s_kept     <= '0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      r_kept     <= r_kept_next;
      s_kept     <= s_kept_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    r_kept_next     = r_kept;
    s_kept_next     = s_kept;
    push            = 1'b0;
    push_item.kind  = RK_BYTE;
    push_item.data  = b;
    push_item.count = '0;
    if (in_fire) begin
      if (in_data.first) begin
        bytes_left_next = '0;
        r_kept_next     = '0;
        s_kept_next     = '0;
        if (b != TagSequence) begin
          phase_next     = PH_DONE;
          push           = 1'b1;
          push_item.kind = RK_FAULT;
        end else begin
          phase_next = PH_SEQ_LEN;
        end
      end else begin
        unique case (phase)
          PH_SEQ_LEN: phase_next = PH_R_TAG;
          PH_R_TAG: begin
            if (b != TagInteger) begin
              phase_next     = PH_DONE;
              push           = 1'b1;
              push_item.kind = RK_FAULT;
            end else begin
              phase_next = PH_R_LEN;
            end
          end
          PH_R_LEN: begin
            if (b > max_raw_bytes) begin
              phase_next     = PH_DONE;
              push           = 1'b1;
              push_item.kind = RK_FAULT;
            end else if (b == PaddedLen) begin
              r_kept_next     = KeptPadLen;
              bytes_left_next = KeptPadLen;
              phase_next      = PH_R_PAD;
            end else begin
              r_kept_next     = b;
              bytes_left_next = b;
              phase_next      = (b == 8'd0) ? PH_S_TAG : PH_R_DATA;
            end
          end
          PH_R_PAD: phase_next = PH_R_DATA;
          PH_R_DATA: begin
            bytes_left_next = dec;
            if (dec == 8'd0) begin
              phase_next = PH_S_TAG;
            end
            push           = 1'b1;
            push_item.kind = RK_BYTE;
          end
          PH_S_TAG: begin
            if (b != TagInteger) begin
              phase_next     = PH_DONE;
              push           = 1'b1;
              push_item.kind = RK_FAULT;
            end else begin
              phase_next = PH_S_LEN;
            end
          end
          PH_S_LEN: begin
            if ((b > s_limit) || (r_kept > max_raw_bytes)) begin
              phase_next     = PH_DONE;
              push           = 1'b1;
              push_item.kind = RK_FAULT;
            end else if (b == PaddedLen) begin
              s_kept_next     = KeptPadLen;
              bytes_left_next = KeptPadLen;
              phase_next      = PH_S_PAD;
            end else begin
              s_kept_next     = b;
              bytes_left_next = b;
              if (b == 8'd0) begin
                // empty s: close the signature right here
                phase_next      = PH_DONE;
                push            = 1'b1;
                push_item.kind  = RK_TOTAL;
                push_item.count = r_kept;
              end else begin
                phase_next = PH_S_DATA;
              end
            end
          end
          PH_S_PAD: phase_next = PH_S_DATA;
          PH_S_DATA: begin
            bytes_left_next = dec;
            push            = 1'b1;
            if (dec == 8'd0) begin
              phase_next      = PH_DONE;
              push_item.kind  = RK_LAST;
              push_item.count = r_kept + s_kept;
            end else begin
              push_item.kind = RK_BYTE;
            end
          end
          PH_IDLE, PH_DONE: ;
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  a_fault_ends_parse: assert property (@(posedge clk) disable iff (rst)
    push && (push_item.kind == RK_FAULT) |=> phase == PH_DONE)
    else $error("fault did not end the parse");

  a_quiet_when_stopped: assert property (@(posedge clk) disable iff (rst)
    in_fire && !in_data.first && (phase == PH_IDLE || phase == PH_DONE) |-> !push)
    else $error("result produced outside a parse");

  a_data_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_R_DATA || phase == PH_S_DATA) |-> bytes_left != 8'd0)
    else $error("data phase with no bytes left");

endmodule

// File: rtl/core/dsr_queue.sv
module dsr_queue import dsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_item_t push_item,
  output logic      q_ready,
  output logic      q_valid,
  output res_item_t q_item,
  input  logic      pop
);

  res_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule

// File: rtl/core/dsr_back.sv
module dsr_back import dsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  res_item_t q_item,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output raw_out_t  out_data
);

  raw_out_t res;

  // Expand a classified item into the result fields
  always_comb begin
    res = '0;
    unique case (q_item.kind)
      RK_BYTE: begin
        res.raw_byte = q_item.data;
        res.has_byte = 1'b1;
      end
      RK_LAST: begin
        res.raw_byte  = q_item.data;
        res.has_byte  = 1'b1;
        res.is_last   = 1'b1;
        res.raw_count = q_item.count;
      end
      RK_TOTAL: begin
        res.is_last   = 1'b1;
        res.raw_count = q_item.count;
      end
      RK_FAULT: res.fault = 1'b1;
      default: res = '0;
    endcase
  end

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

endmodule
